[src/rgb_to_luv_pixel_defines.svh]
// Assertion helpers for the top-level RTL.
`ifndef RGB_TO_LUV_PIXEL_DEFINES_SVH
`define RGB_TO_LUV_PIXEL_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define RLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/rgb2luv_pkg.sv]
package rgb2luv_pkg;

  // Cube-root table geometry
  localparam int ROOT_TABLE_SIZE = 2048;
  localparam int ROOT_IDX_W      = $clog2(ROOT_TABLE_SIZE);
  localparam int RAW_IDX_W       = ROOT_IDX_W + 1;
  localparam int ROOT_W          = 17;

  // Datapath widths
  localparam int SUM_W = 25;
  localparam int XYZ_W = 17;
  localparam int DEN_W = 21;
  localparam int NUM_W = 36;
  localparam int QUO_W = 19;
  localparam int L_W   = 23;
  localparam int P_W   = 44;
  localparam int W_W   = 48;
  localparam int T_W   = 57;
  localparam int H_W   = 17;

  // RGB to XYZ matrix, Q16
  localparam logic [15:0] KXR = 16'd27031;
  localparam logic [15:0] KXG = 16'd23434;
  localparam logic [15:0] KXB = 16'd11824;
  localparam logic [15:0] KYR = 16'd13938;
  localparam logic [15:0] KYG = 16'd46869;
  localparam logic [15:0] KYB = 16'd4730;
  localparam logic [15:0] KZR = 16'd1267;
  localparam logic [15:0] KZG = 16'd7811;
  localparam logic [15:0] KZB = 16'd62274;

  // Divide by 255 through reciprocal multiply
  localparam logic [25:0] RECIP255    = 26'd33686019;
  localparam int          RECIP255_SH = 33;

  // White point chromaticity, Q16
  localparam logic signed [19:0] UREF = 20'sd12965;
  localparam logic signed [19:0] VREF = 20'sd30692;

  // L offset of 16.0 in Q16
  localparam logic [L_W:0] L_OFS = (L_W + 1)'(16 * 65536);

  // Chroma offsets in Q32
  localparam logic signed [W_W-1:0] U_OFS = W_W'(134) << 32;
  localparam logic signed [W_W-1:0] V_OFS = W_W'(140) << 32;

  // Final scaling reciprocals and saturation thresholds
  localparam logic [15:0] RECIP100    = 16'd41944;
  localparam int          RECIP100_SH = 22;
  localparam logic [17:0] RECIP354    = 18'd189574;
  localparam logic [17:0] RECIP262    = 18'd256141;
  localparam int          RECIP_SH    = 26;
  localparam logic [24:0] SAT_U_H     = 25'd90624;
  localparam logic [24:0] SAT_V_H     = 25'd67072;

  typedef logic [ROOT_W-1:0] root_tab_t [ROOT_TABLE_SIZE];

  // Build the cube-root table: entry i is floor(cbrt(i/(N-1)) * 65536)
  function automatic root_tab_t root_table_gen();
    root_tab_t   tab;
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    for (int i = 0; i < ROOT_TABLE_SIZE; i++) begin
      target = 64'(i) << 48;
      lo     = 64'd0;
      hi     = 64'd65536;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (mid * mid * mid * 64'(ROOT_TABLE_SIZE - 1) <= target) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
      tab[i] = ROOT_W'(lo);
    end
    return tab;
  endfunction

endpackage

[src/rgb2luv_xyz.sv]
module rgb2luv_xyz (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 valid_i,
  input  logic [7:0]                           red,
  input  logic [7:0]                           green,
  input  logic [7:0]                           blue,
  output logic                                 valid_o,
  output logic [rgb2luv_pkg::NUM_W-1:0]        num_u,
  output logic [rgb2luv_pkg::NUM_W-1:0]        num_v,
  output logic [rgb2luv_pkg::DEN_W-1:0]        den,
  output logic [rgb2luv_pkg::RAW_IDX_W-1:0]    idx_raw
);

  localparam int SW   = rgb2luv_pkg::SUM_W;
  localparam int XW   = rgb2luv_pkg::XYZ_W;
  localparam int DW   = rgb2luv_pkg::DEN_W;
  localparam int NW   = rgb2luv_pkg::NUM_W;
  localparam int MW   = SW + 26;
  localparam int IPW  = XW + rgb2luv_pkg::ROOT_IDX_W;

  logic [2:0]    vld_r;
  logic [SW-1:0] sx_r, sy_r, sz_r;
  logic [XW-1:0] x_r, y_r, z_r;
  logic [MW-1:0] px, py, pz;
  logic [DW-1:0] den_sum;
  logic [19:0]   v9;
  logic [IPW-1:0] iprod;
  logic [NW-1:0] num_u_r, num_v_r;
  logic [DW-1:0] den_r;
  logic [rgb2luv_pkg::RAW_IDX_W-1:0] idx_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], valid_i};
    end
  end

  // Divide sums by 255 through reciprocal multiply
  assign px = MW'(sx_r) * MW'(rgb2luv_pkg::RECIP255);
  assign py = MW'(sy_r) * MW'(rgb2luv_pkg::RECIP255);
  assign pz = MW'(sz_r) * MW'(rgb2luv_pkg::RECIP255);

  // Form divisor, numerators and table index product
  assign den_sum = DW'(x_r) + DW'({y_r, 4'b0000}) - DW'(y_r) + DW'({z_r, 1'b0}) + DW'(z_r);
  assign v9      = 20'({y_r, 3'b000}) + 20'(y_r);
  assign iprod   = IPW'(y_r) * IPW'(rgb2luv_pkg::ROOT_TABLE_SIZE - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= SW'(rgb2luv_pkg::KXR) * SW'(red) + SW'(rgb2luv_pkg::KXG) * SW'(green)
            + SW'(rgb2luv_pkg::KXB) * SW'(blue);
      sy_r <= SW'(rgb2luv_pkg::KYR) * SW'(red) + SW'(rgb2luv_pkg::KYG) * SW'(green)
            + SW'(rgb2luv_pkg::KYB) * SW'(blue);
      sz_r <= SW'(rgb2luv_pkg::KZR) * SW'(red) + SW'(rgb2luv_pkg::KZG) * SW'(green)
            + SW'(rgb2luv_pkg::KZB) * SW'(blue);
      x_r  <= px[rgb2luv_pkg::RECIP255_SH +: XW];
      y_r  <= py[rgb2luv_pkg::RECIP255_SH +: XW];
      z_r  <= pz[rgb2luv_pkg::RECIP255_SH +: XW];
      // Floor a black pixel's divisor at one LSB
      den_r   <= (den_sum == '0) ? DW'(1) : den_sum;
      num_u_r <= NW'({x_r, 18'b0});
      num_v_r <= NW'({v9, 16'b0});
      idx_r   <= iprod[16 +: rgb2luv_pkg::RAW_IDX_W];
    end
  end

  assign valid_o = vld_r[2];
  assign num_u   = num_u_r;
  assign num_v   = num_v_r;
  assign den     = den_r;
  assign idx_raw = idx_r;

endmodule

[src/rgb2luv_div.sv]
module rgb2luv_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           valid_i,
  input  logic [rgb2luv_pkg::NUM_W-1:0]  num,
  input  logic [rgb2luv_pkg::DEN_W-1:0]  den,
  output logic                           valid_o,
  output logic [rgb2luv_pkg::QUO_W-1:0]  quo
);

  localparam int DW = rgb2luv_pkg::DEN_W;
  localparam int QW = rgb2luv_pkg::QUO_W;
  localparam int NW = rgb2luv_pkg::NUM_W;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic [DW-1:0] den;
  } dstage_t;

  // One restoring step: shift in a dividend bit, subtract when it fits
  function automatic dstage_t div_step(dstage_t a);
    dstage_t     b;
    logic [DW:0] trial;
    trial = {a.rem, a.low[QW-1]};
    b     = a;
    b.low = a.low << 1;
    if (trial >= {1'b0, a.den}) begin
      b.rem = DW'(trial - {1'b0, a.den});
      b.quo = {a.quo[QW-2:0], 1'b1};
    end else begin
      b.rem = trial[DW-1:0];
      b.quo = {a.quo[QW-2:0], 1'b0};
    end
    return b;
  endfunction

  dstage_t       first;
  dstage_t       st_r [QW];
  logic [QW-1:0] vld_r;

  // Quotient stays below 2^QW, so the top dividend bits start below the divisor
  assign first.rem = DW'(num[NW-1:QW]);
  assign first.low = num[QW-1:0];
  assign first.quo = '0;
  assign first.den = den;

  // Advance one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_step(first);
      for (int s = 1; s < QW; s++) begin
        st_r[s] <= div_step(st_r[s-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], valid_i};
    end
  end

  assign valid_o = vld_r[QW-1];
  assign quo     = st_r[QW-1].quo;

endmodule

[src/rgb2luv_root.sv]
module rgb2luv_root (
  input  logic                               clk,
  input  logic                               en,
  input  logic [rgb2luv_pkg::RAW_IDX_W-1:0]  idx_raw,
  output logic [rgb2luv_pkg::L_W-1:0]        light_q
);

  localparam int IW = rgb2luv_pkg::ROOT_IDX_W;
  localparam int LW = rgb2luv_pkg::L_W;
  localparam int DLY = rgb2luv_pkg::QUO_W - 2;

  localparam rgb2luv_pkg::root_tab_t ROOT_ROM = rgb2luv_pkg::root_table_gen();

  logic [IW-1:0]                  idx;
  logic [rgb2luv_pkg::ROOT_W-1:0] root_r;
  logic [LW:0]                    l116;
  logic [LW-1:0]                  l_dly_r [DLY + 1];

  // Clamp the index when Y lands one LSB above one
  assign idx = (idx_raw > rgb2luv_pkg::RAW_IDX_W'(rgb2luv_pkg::ROOT_TABLE_SIZE - 1))
             ? IW'(rgb2luv_pkg::ROOT_TABLE_SIZE - 1) : idx_raw[IW-1:0];

  assign l116 = (LW + 1)'(root_r) * (LW + 1)'(116);

  // Read table, form L = max(0, 116*root - 16), delay to match divider
  always_ff @(posedge clk) begin
    if (en) begin
      root_r     <= ROOT_ROM[idx];
      l_dly_r[0] <= (l116 < rgb2luv_pkg::L_OFS) ? '0 : LW'(l116 - rgb2luv_pkg::L_OFS);
      for (int s = 1; s <= DLY; s++) begin
        l_dly_r[s] <= l_dly_r[s-1];
      end
    end
  end

  assign light_q = l_dly_r[DLY];

endmodule

[src/rgb2luv_scale.sv]
module rgb2luv_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic [rgb2luv_pkg::QUO_W-1:0] uq,
  input  logic [rgb2luv_pkg::QUO_W-1:0] vq,
  input  logic [rgb2luv_pkg::L_W-1:0]   light_q,
  output logic                          valid_o,
  output logic [7:0]                    light,
  output logic [7:0]                    chroma_u,
  output logic [7:0]                    chroma_v
);

  localparam int PW = rgb2luv_pkg::P_W;
  localparam int WW = rgb2luv_pkg::W_W;
  localparam int TW = rgb2luv_pkg::T_W;
  localparam int HW = rgb2luv_pkg::H_W;
  localparam int LW = rgb2luv_pkg::L_W;

  logic [3:0]            vld_r;
  logic signed [19:0]    du, dv;
  logic signed [PW-1:0]  l_s, pu_nxt, pv_nxt;
  logic signed [PW-1:0]  pu_r, pv_r;
  logic [LW+7:0]         l255;
  logic [14:0]           lh_r;
  logic [30:0]           lprod;
  logic [8:0]            lq;
  logic [7:0]            light_p2_r, light_p3_r, light_p4_r;
  logic signed [WW-1:0]  wu_r, wv_r;
  logic signed [TW-1:0]  tu, tv;
  logic                  pos_u, pos_v;
  logic [24:0]           hu, hv;
  logic [HW-1:0]         hu_r, hv_r;
  logic                  sat_u_r, sat_v_r;
  logic [34:0]           qu_p, qv_p;
  logic [8:0]            qu, qv;
  logic [7:0]            cu_r, cv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], valid_i};
    end
  end

  // Stage 1: L*(u - uref), L*(v - vref), L*255 >> 16
  assign du     = $signed({1'b0, uq}) - rgb2luv_pkg::UREF;
  assign dv     = $signed({1'b0, vq}) - rgb2luv_pkg::VREF;
  assign l_s    = $signed(PW'(light_q));
  assign pu_nxt = l_s * PW'(du);
  assign pv_nxt = l_s * PW'(dv);
  assign l255   = (LW + 8)'({light_q, 8'b0}) - (LW + 8)'(light_q);

  // Stage 2: 13x plus offset; L / 100
  assign lprod = 31'(lh_r) * 31'(rgb2luv_pkg::RECIP100);
  assign lq    = lprod[rgb2luv_pkg::RECIP100_SH +: 9];

  // Stage 3: times 255, whole part of the Q32 value
  assign tu    = (TW'(wu_r) <<< 8) - TW'(wu_r);
  assign tv    = (TW'(wv_r) <<< 8) - TW'(wv_r);
  assign pos_u = !wu_r[WW-1] && (wu_r != '0);
  assign pos_v = !wv_r[WW-1] && (wv_r != '0);
  assign hu    = pos_u ? tu[TW-1:32] : '0;
  assign hv    = pos_v ? tv[TW-1:32] : '0;

  // Stage 4: divide by span through reciprocal multiply
  assign qu_p = 35'(hu_r) * 35'(rgb2luv_pkg::RECIP354);
  assign qv_p = 35'(hv_r) * 35'(rgb2luv_pkg::RECIP262);
  assign qu   = qu_p[rgb2luv_pkg::RECIP_SH +: 9];
  assign qv   = qv_p[rgb2luv_pkg::RECIP_SH +: 9];

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r       <= pu_nxt;
      pv_r       <= pv_nxt;
      lh_r       <= l255[16 +: 15];
      wu_r       <= (WW'(pu_r) <<< 3) + (WW'(pu_r) <<< 2) + WW'(pu_r) + rgb2luv_pkg::U_OFS;
      wv_r       <= (WW'(pv_r) <<< 3) + (WW'(pv_r) <<< 2) + WW'(pv_r) + rgb2luv_pkg::V_OFS;
      light_p2_r <= lq[8] ? 8'hFF : lq[7:0];
      hu_r       <= hu[HW-1:0];
      hv_r       <= hv[HW-1:0];
      sat_u_r    <= hu >= rgb2luv_pkg::SAT_U_H;
      sat_v_r    <= hv >= rgb2luv_pkg::SAT_V_H;
      light_p3_r <= light_p2_r;
      cu_r       <= (sat_u_r || qu[8]) ? 8'hFF : qu[7:0];
      cv_r       <= (sat_v_r || qv[8]) ? 8'hFF : qv[7:0];
      light_p4_r <= light_p3_r;
    end
  end

  assign valid_o  = vld_r[3];
  assign light    = light_p4_r;
  assign chroma_u = cu_r;
  assign chroma_v = cv_r;

endmodule

[src/rgb_to_luv_pixel.sv]
// Pipeline from an accepted input transaction to out_valid: 3 XYZ stages,
// 19 divider stages, one quotient bit each, 4 scaling stages, 1 output register.
// Throughput: one pixel per cycle unless stalled; the skid register holds one more result.
// Reset (rst_n low, synchronous) clears all valid bits and the skid; datapath is not reset.
module rgb_to_luv_pixel (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_light,
  output logic [7:0] out_chroma_u,
  output logic [7:0] out_chroma_v
);

`include "rgb_to_luv_pixel_defines.svh"

  logic                                en;
  logic                                xyz_vld;
  logic [rgb2luv_pkg::NUM_W-1:0]       num_u, num_v;
  logic [rgb2luv_pkg::DEN_W-1:0]       den;
  logic [rgb2luv_pkg::RAW_IDX_W-1:0]   idx_raw;
  logic                                div_vld;
  logic                                div_v_vld;
  logic [rgb2luv_pkg::QUO_W-1:0]       uq, vq;
  logic [rgb2luv_pkg::L_W-1:0]         light_q;
  logic                                fin_vld;
  logic [7:0]                          fin_l, fin_u, fin_v;
  logic                                out_vld_r, skid_vld_r;
  logic [7:0]                          out_l_r, out_u_r, out_v_r;
  logic [7:0]                          skid_l_r, skid_u_r, skid_v_r;

  // Freeze the pipeline only while the skid holds a result
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  rgb2luv_xyz u_xyz (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(in_valid && !in_stall),
    .red(in_red), .green(in_green), .blue(in_blue),
    .valid_o(xyz_vld), .num_u(num_u), .num_v(num_v), .den(den), .idx_raw(idx_raw)
  );

  rgb2luv_div u_div_u (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(xyz_vld),
    .num(num_u), .den(den), .valid_o(div_vld), .quo(uq)
  );

  rgb2luv_div u_div_v (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(xyz_vld),
    .num(num_v), .den(den), .valid_o(div_v_vld), .quo(vq)
  );

  rgb2luv_root u_root (
    .clk(clk), .en(en), .idx_raw(idx_raw), .light_q(light_q)
  );

  rgb2luv_scale u_scale (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(div_vld),
    .uq(uq), .vq(vq), .light_q(light_q),
    .valid_o(fin_vld), .light(fin_l), .chroma_u(fin_u), .chroma_v(fin_v)
  );

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!skid_vld_r) begin
      if (out_vld_r && out_stall) begin
        skid_vld_r <= fin_vld;
      end else begin
        out_vld_r <= fin_vld;
      end
    end else if (!out_stall) begin
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      if (out_vld_r && out_stall) begin
        skid_l_r <= fin_l;
        skid_u_r <= fin_u;
        skid_v_r <= fin_v;
      end else begin
        out_l_r <= fin_l;
        out_u_r <= fin_u;
        out_v_r <= fin_v;
      end
    end else if (!out_stall) begin
      out_l_r <= skid_l_r;
      out_u_r <= skid_u_r;
      out_v_r <= skid_v_r;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_light    = out_l_r;
  assign out_chroma_u = out_u_r;
  assign out_chroma_v = out_v_r;

  `RLP_ASSERT_NOW(a_skid_has_out, skid_vld_r, out_vld_r, "skid full without output")
  `RLP_ASSERT_NEXT(a_skid_holds, skid_vld_r && out_stall, skid_vld_r, "skid dropped a result")
  `RLP_ASSERT_NEXT(a_skid_fill, !skid_vld_r && !(out_vld_r && out_stall), !skid_vld_r, "skid filled without stall")
  `RLP_ASSERT_NOW(a_div_align, 1'b1, div_vld == div_v_vld, "divider lanes out of step")

endmodule
